>>> rtl/core/cppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppc_pkg: shared types and codes for the convex polygon containment block
// Commands, side codes and the sequencer state type.
// ----------------------------------------------------------------------------
package cppc_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] SIDE_BELOW = 2'd0;
  localparam logic [1:0] SIDE_ABOVE = 2'd1;
  localparam logic [1:0] SIDE_ON    = 2'd2;
  localparam logic [1:0] SIDE_NONE  = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RDE   = 7'b0000010,  // read edge ends
    ST_RDP   = 7'b0000100,  // read test point
    ST_MUL   = 7'b0001000,  // products registered
    ST_CMP   = 7'b0010000,  // compare and accumulate
    ST_WB    = 7'b0100000,  // write edge class back
    ST_OUT   = 7'b1000000
  } state_t;

endpackage

>>> rtl/core/convex_polygon_point_containment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_point_containment
// Vertex table with edge side classes; add, query and clear commands.
// ----------------------------------------------------------------------------
// One item in, one result out. Vertices live in a synchronous memory with
// one read port. Each side test reads the point, preceded on the first test
// of an edge by its two ends, then passes a multiply state and a compare
// state. A query tests the point against every edge of a convex table; an
// add tests every vertex against every edge. Clear, the unused code, a query
// on a table that is not convex and an add to a full table go straight to
// the output state. A result waits in its own output register, so the next
// item is accepted while it waits; a second finished result holds the
// sequencer until the first is taken.
module convex_polygon_point_containment
  import cppc_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [1:0] cmd, [COORD_WIDTH+1:2] x_coord, [2*COORD_WIDTH+1:COORD_WIDTH+2] y_coord
  input  logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [0] convex, [1] inside_res, [8:2] vertex_count, [9] full_error
  output logic [15:0] out_tdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // vertex memory and edge class memory
  logic [2*COORD_WIDTH-1:0] vmem [MAX_VERTICES];
  logic [1:0]               cmem [MAX_VERTICES];

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic          convex_r, ok_r, inside_r, fresh_r;
  logic [1:0]    cmd_r, cls_r;
  logic signed [COORD_WIDTH-1:0] qx_r, qy_r;
  logic [AW-1:0] i_r, j_r, k_r;
  logic [AW-1:0] raddr;
  logic [2*COORD_WIDTH-1:0] rdata_r;
  logic [1:0] crd_r;
  logic signed [COORD_WIDTH-1:0] xa_r, ya_r, xb_r, yb_r, xp_r, yp_r;
  logic signed [PW-1:0] m1_r, m2_r;
  logic vert_r, degen_r, runneg_r;
  logic [1:0] rdph_r;
  logic ov_r;
  logic [15:0] od_r;
  logic [15:0] res_r;

  wire [1:0] in_cmd = in_tdata[1:0];
  wire signed [COORD_WIDTH-1:0] in_x = in_tdata[COORD_WIDTH+1:2];
  wire signed [COORD_WIDTH-1:0] in_y = in_tdata[2*COORD_WIDTH+1:COORD_WIDTH+2];
  wire in_fire  = in_tvalid && in_tready;
  wire out_free = !ov_r || out_tready;
  wire [CW-1:0] i_ext = CW'(i_r);
  wire [CW-1:0] j_ext = CW'(j_r);
  wire last_i = (i_ext + CW'(1) == cnt_r);
  wire last_j = (j_ext + CW'(1) == cnt_r);
  wire is_add = (cmd_r == CMD_ADD);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // side of point from registered products
  logic [1:0] side;
  always_comb begin
    side = SIDE_ON;
    if (vert_r) begin
      if (degen_r)      side = SIDE_ON;
      else if (xp_r > xa_r) side = SIDE_BELOW;
      else if (xp_r < xa_r) side = SIDE_ABOVE;
    end else if (m1_r != m2_r) begin
      side = ((m1_r > m2_r) ^ runneg_r) ? SIDE_BELOW : SIDE_ABOVE;
    end
  end

  // memory read address: edge start, edge end, then point
  always_comb begin
    case (rdph_r)
      2'd0:    raddr = i_r;
      2'd1:    raddr = k_r;
      default: raddr = j_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= vmem[raddr];
    crd_r   <= cmem[i_r];
    if (state_r == ST_IDLE && in_fire && in_cmd == CMD_ADD &&
        cnt_r < CW'(MAX_VERTICES))
      vmem[cnt_r[AW-1:0]] <= {in_y, in_x};
    if (state_r == ST_WB && is_add)
      cmem[i_r] <= (cnt_r < CW'(3)) ? SIDE_NONE : cls_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0; convex_r <= 1'b0; ov_r <= 1'b0; rdph_r <= 2'd0;
    end else begin
      // output register: loaded from ST_OUT, cleared when taken
      if (state_r == ST_OUT && out_free) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_fire) begin
          cmd_r <= in_cmd; qx_r <= in_x; qy_r <= in_y;
          inside_r <= (in_cmd == CMD_QUERY) && convex_r && (cnt_r != '0);
          ok_r <= 1'b1;
          i_r <= '0; rdph_r <= 2'd0;
          k_r <= ((in_cmd == CMD_ADD) ? (cnt_r == CW'(0)) : (cnt_r == CW'(1))) ?
                 AW'(0) : AW'(1);
          if (in_cmd == CMD_ADD) begin
            if (cnt_r >= CW'(MAX_VERTICES)) begin
              res_r <= {6'd0, 1'b1, 7'(cnt_r), 1'b0, convex_r};
              state_r <= ST_OUT;
            end else begin
              cnt_r <= cnt_r + CW'(1);
              j_r <= '0; fresh_r <= 1'b1; cls_r <= SIDE_NONE;
              state_r <= ST_RDE;
            end
          end else if (in_cmd == CMD_QUERY && convex_r && cnt_r != '0) begin
            state_r <= ST_RDE;
          end else begin
            if (in_cmd == CMD_CLEAR) begin
              cnt_r <= '0; convex_r <= 1'b0;
              res_r <= 16'd0;
            end else
              res_r <= {6'd0, 1'b0, 7'(cnt_r), 1'b0, convex_r};
            state_r <= ST_OUT;
          end
        end
        ST_RDE: begin
          // two reads: edge start then edge end
          if (rdph_r == 2'd0) rdph_r <= 2'd1;
          else begin
            rdph_r <= 2'd2;
            {ya_r, xa_r} <= rdata_r;
            state_r <= ST_RDP;
          end
        end
        ST_RDP: begin
          if (rdph_r == 2'd2) begin
            // edge end is on the read data only on the first pass of an edge
            if (!is_add || j_r == '0) {yb_r, xb_r} <= rdata_r;
            rdph_r <= 2'd3;
          end else begin
            if (is_add) {yp_r, xp_r} <= rdata_r;
            else begin xp_r <= qx_r; yp_r <= qy_r; end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          // sign(rise*dx - dy*run) * sign(run)
          m1_r <= PW'(DW'(yb_r) - DW'(ya_r)) * PW'(DW'(xp_r) - DW'(xa_r));
          m2_r <= PW'(DW'(yp_r) - DW'(ya_r)) * PW'(DW'(xb_r) - DW'(xa_r));
          vert_r <= (xb_r == xa_r); degen_r <= (yb_r == ya_r);
          runneg_r <= (xb_r < xa_r);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (!is_add) begin
            if (side != SIDE_ON && side != crd_r) inside_r <= 1'b0;
            if (last_i) begin
              res_r <= {6'd0, 1'b0, 7'(cnt_r), inside_r &&
                        !(side != SIDE_ON && side != crd_r), convex_r};
              state_r <= ST_OUT;
            end else begin
              i_r <= i_r + AW'(1);
              k_r <= (i_ext + CW'(2) == cnt_r) ? AW'(0) : i_r + AW'(2);
              rdph_r <= 2'd0; state_r <= ST_RDE;
            end
          end else begin
            if (j_r != i_r && j_r != k_r && side != SIDE_ON) begin
              if (fresh_r) begin cls_r <= side; fresh_r <= 1'b0; end
              else if (side != cls_r) cls_r <= SIDE_NONE;
            end
            if (last_j) state_r <= ST_WB;
            else begin
              j_r <= j_r + AW'(1); rdph_r <= 2'd2; state_r <= ST_RDP;
            end
          end
        end
        ST_WB: begin
          if (cnt_r < CW'(3) || cls_r == SIDE_NONE) ok_r <= 1'b0;
          if (last_i) begin
            convex_r <= ok_r && cnt_r >= CW'(3) && cls_r != SIDE_NONE;
            res_r <= {6'd0, 1'b0, 7'(cnt_r), 1'b0,
                      ok_r && cnt_r >= CW'(3) && cls_r != SIDE_NONE};
            state_r <= ST_OUT;
          end else begin
            i_r <= i_r + AW'(1);
            k_r <= (i_ext + CW'(2) == cnt_r) ? AW'(0) : i_r + AW'(2);
            j_r <= '0; fresh_r <= 1'b1; cls_r <= SIDE_NONE;
            rdph_r <= 2'd0; state_r <= ST_RDE;
          end
        end
        ST_OUT: if (out_free) begin
          od_r <= res_r; state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_VERTICES)) else $error("count overflow");
  a_cvx: assert property (@(posedge clk) disable iff (!rst_n)
    convex_r |-> cnt_r >= CW'(3)) else $error("convex below three");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r && $stable(od_r)) else $error("result lost");
`endif

endmodule

>>> tb/sv/tb_convex_polygon_point_containment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_polygon_point_containment
// Self-checking bench for the convex polygon containment block.
// ----------------------------------------------------------------------------
// Items are add, query, clear and the unused code, sent through the input
// stream in random bursts. The bench keeps its own vertex table and edge side
// classes and predicts each result. The result stream stalls on its own
// pattern, and every result is checked field by field against the oldest
// prediction. Most polygons are small and convex, built from a fixed set of
// directions; one run fills the table to its limit with a convex shape.
// ----------------------------------------------------------------------------
module tb_convex_polygon_point_containment;
  import cppc_pkg::*;

  localparam int        NV          = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint    CYCLE_LIMIT = 6000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [1:0] cmd, [17:2] x_coord, [33:18] y_coord
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [0] convex, [1] inside_res, [8:2] vertex_count, [9] full_error

  convex_polygon_point_containment dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow polygon state
  longint     poly_x [NV];
  longint     poly_y [NV];
  logic [1:0] edge_cls [NV];
  int         poly_n;
  logic       poly_convex;

  logic [9:0] result_q [$];   // {full_error, vertex_count, inside_res, convex}
  int         n_add, n_query, n_clear, n_inside, n_full;
  int         n_fail = 0;
  int         n_results = 0;
  longint     cycles = 0;
  int         burst_left;

  // side of point p relative to the line through a and b
  function automatic logic [1:0] side_of(longint xa, longint ya, longint xb, longint yb,
                                         longint xp, longint yp);
    longint run, cr;
    run = xb - xa;
    if (run == 0) begin
      if (ya == yb) return SIDE_ON;
      if (xp > xa) return SIDE_BELOW;
      if (xp < xa) return SIDE_ABOVE;
      return SIDE_ON;
    end
    cr = (yb - ya) * (xp - xa) - (yp - ya) * run;
    if (run < 0) cr = -cr;
    if (cr > 0) return SIDE_BELOW;
    if (cr < 0) return SIDE_ABOVE;
    return SIDE_ON;
  endfunction

  // rebuild all edge classes and the convex flag
  function automatic void reclassify();
    int k;
    logic [1:0] cls, s;
    logic ok, fresh;
    ok = (poly_n >= 3);
    for (int i = 0; i < poly_n; i++) begin
      k = (i + 1 == poly_n) ? 0 : i + 1;
      cls = SIDE_NONE;
      fresh = 1'b1;
      if (poly_n >= 3) begin
        for (int j = 0; j < poly_n; j++) begin
          if (j == i || j == k) continue;
          s = side_of(poly_x[i], poly_y[i], poly_x[k], poly_y[k], poly_x[j], poly_y[j]);
          if (s == SIDE_ON) continue;
          if (fresh) begin
            cls = s;
            fresh = 1'b0;
          end else if (s != cls) begin
            cls = SIDE_NONE;
          end
        end
      end
      edge_cls[i] = cls;
      if (cls == SIDE_NONE) ok = 1'b0;
    end
    poly_convex = ok;
  endfunction

  function automatic logic contains(longint x, longint y);
    int k;
    logic [1:0] s;
    if (!poly_convex || poly_n == 0) return 1'b0;
    for (int i = 0; i < poly_n; i++) begin
      k = (i + 1 == poly_n) ? 0 : i + 1;
      s = side_of(poly_x[i], poly_y[i], poly_x[k], poly_y[k], x, y);
      if (s != SIDE_ON && s != edge_cls[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the shadow state by one accepted item, return the expected result
  function automatic logic [9:0] predict_item(logic [1:0] cmd, logic signed [15:0] x,
                                              logic signed [15:0] y);
    logic hit, full;
    logic [6:0] cnt;
    hit = 1'b0;
    full = 1'b0;
    case (cmd)
      CMD_ADD: begin
        n_add++;
        if (poly_n >= NV) begin
          full = 1'b1;
          n_full++;
        end else begin
          poly_x[poly_n] = x;
          poly_y[poly_n] = y;
          poly_n++;
          reclassify();
        end
      end
      CMD_QUERY: begin
        n_query++;
        hit = contains(x, y);
        if (hit) n_inside++;
      end
      CMD_CLEAR: begin
        n_clear++;
        poly_n = 0;
        poly_convex = 1'b0;
      end
      default: ;
    endcase
    cnt = poly_n[6:0];
    return {full, cnt, hit, poly_convex};
  endfunction

  // send one item, record its prediction on acceptance, then maybe idle
  task automatic send_item(logic [1:0] cmd, int x, int y);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, 16'(y), 16'(x), cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_q = {result_q, predict_item(cmd, 16'(x), 16'(y))};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 10);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic int rnd_coord();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 3)) - 32768;
      1:       return 32767 - int'($urandom_range(0, 3));
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // convex directions; any ordered subset gives a convex polygon
  function automatic int dir_x(int i);
    int t [8] = '{3, 2, 0, -2, -3, -2, 0, 2};
    return t[i];
  endfunction
  function automatic int dir_y(int i);
    int t [8] = '{0, 2, 3, 2, 0, -2, -3, -2};
    return t[i];
  endfunction

  // random small convex polygon after a clear, then queries in and around it or anywhere
  task automatic random_polygon();
    int sc, cx, cy, nq, q;
    int px, py, pick [$];
    sc = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 3000);
    cx = $signed($urandom_range(0, 40000)) - 20000;
    cy = $signed($urandom_range(0, 40000)) - 20000;
    send_item(CMD_CLEAR, $urandom, $urandom);
    for (int i = 0; i < 8; i++)
      if ($urandom_range(0, 1)) pick = {pick, i};
    while (pick.size() < 3) pick = {pick, pick.size() * 3};
    pick.sort();
    if ($urandom_range(0, 1)) pick.reverse();
    for (int i = 0; i < pick.size(); i++)
      send_item(CMD_ADD, cx + sc * dir_x(pick[i]), cy + sc * dir_y(pick[i]));
    nq = $urandom_range(2, 10);
    for (int i = 0; i < nq; i++) begin
      q = pick[$urandom_range(0, pick.size() - 1)];
      case ($urandom_range(0, 3))
        0: begin px = cx + sc * dir_x(q); py = cy + sc * dir_y(q); end
        1: begin
          px = cx + $signed($urandom_range(0, 6 * sc)) - 3 * sc;
          py = cy + $signed($urandom_range(0, 6 * sc)) - 3 * sc;
        end
        2: begin
          px = cx + $signed($urandom_range(0, 2 * sc)) - sc;
          py = cy + $signed($urandom_range(0, 2 * sc)) - sc;
        end
        default: begin px = $urandom; py = $urandom; end
      endcase
      send_item(CMD_QUERY, px, py);
    end
    // now and then a stray vertex that may break convexity
    if ($urandom_range(0, 3) == 0) begin
      send_item(CMD_ADD, cx + $signed($urandom_range(0, 2 * sc)) - sc,
                cy + $signed($urandom_range(0, 2 * sc)) - sc);
      send_item(CMD_QUERY, cx, cy);
    end
  endtask

  // extremes of the coordinate range, every command, unused code
  task automatic test_directed();
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_ADD, 16'sh8000, 16'sh8000);
    send_item(CMD_QUERY, 16'sh8000, 16'sh8000);
    send_item(CMD_ADD, 16'sh7fff, 16'sh8000);
    send_item(CMD_ADD, 16'sh0000, 16'sh7fff);
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_QUERY, 16'sh7fff, 16'sh7fff);
    send_item(CMD_QUERY, 16'sh0000, 16'sh8000);
    send_item(CMD_UNUSED, 16'shffff, 16'shffff);
    send_item(CMD_QUERY, 16'sh8000, 16'sh7fff);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_QUERY, 0, 0);
  endtask

  // vertical edges, repeated vertices and collinear tables
  task automatic test_degenerate();
    send_item(CMD_ADD, 100, -100);
    send_item(CMD_ADD, 100, 100);
    send_item(CMD_ADD, -100, 100);
    send_item(CMD_ADD, -100, -100);
    send_item(CMD_QUERY, 100, 0);
    send_item(CMD_QUERY, 101, 0);
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_ADD, -100, -100);
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_ADD, 5, 5);
    send_item(CMD_ADD, 5, 5);
    send_item(CMD_ADD, 5, 5);
    send_item(CMD_QUERY, 5, 5);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_ADD, 0, 0);
    send_item(CMD_ADD, 10, 10);
    send_item(CMD_ADD, 20, 20);
    send_item(CMD_QUERY, 10, 10);
  endtask

  // fill the table with a convex shape, then overflow it
  task automatic test_full_table();
    send_item(CMD_CLEAR, 0, 0);
    for (int i = 0; i < NV; i++)
      send_item(CMD_ADD, i * 500 - 16000, (i - 32) * (i - 32) * 20);
    send_item(CMD_QUERY, 0, 15000);
    send_item(CMD_QUERY, 0, -10);
    send_item(CMD_QUERY, -16000, 20480);
    for (int i = 0; i < 3; i++) send_item(CMD_ADD, rnd_coord(), rnd_coord());
    send_item(CMD_QUERY, 100, 19000);
    drain();
    send_item(CMD_CLEAR, 0, 0);
  endtask

  // mostly well-formed polygons, with some noise items in between
  task automatic test_random(int items);
    int start;
    logic [1:0] c;
    start = n_add + n_query + n_clear;
    while (n_add + n_query + n_clear < start + items) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < $urandom_range(1, 6); i++) begin
          c = 2'($urandom);
          if (c == CMD_ADD && poly_n > 12) c = CMD_QUERY;
          send_item(c, rnd_coord(), rnd_coord());
        end
      end else begin
        random_polygon();
      end
      if ($urandom_range(0, 30) == 0) drain();
    end
  endtask

  // receiver stalls in phases: none, random, long holds
  int stall_mode, stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      stall_mode  <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        default: out_tready <= (stall_phase % 23) > 15;
      endcase
    end
  end

  // result checking
  always @(posedge clk) begin
    logic [9:0] exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %h", out_tdata[9:0]);
      end else begin
        exp_res = result_q.pop_front();
        if (out_tdata[9:0] !== exp_res) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: convex %b/%b inside %b/%b count %0d/%0d full %b/%b (exp/act)",
                     exp_res[0], out_tdata[0], exp_res[1], out_tdata[1],
                     exp_res[8:2], out_tdata[8:2], exp_res[9], out_tdata[9]);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    n_add      = 0;
    n_query    = 0;
    n_clear    = 0;
    n_inside   = 0;
    n_full     = 0;
    burst_left = 0;
    poly_n     = 0;
    poly_convex = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_degenerate();
    drain();
    test_full_table();
    test_random(1300);

    drain();
    repeat (200) @(posedge clk);
    $display("ran %0d adds (%0d into a full table), %0d queries (%0d inside), %0d clears",
             n_add, n_full, n_query, n_inside, n_clear);
    $display("checked %0d results, %0d still expected", n_results, result_q.size());
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cppc_pkg.sv
rtl/core/convex_polygon_point_containment.sv
tb/sv/tb_convex_polygon_point_containment.sv
